[rtl/stp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stp_pkg
// shared types, character codes and reset state for the string to integer
// parser
// ----------------------------------------------------------------------------
package stp_pkg;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGN,
    PH_ZERO,
    PH_X,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    BASE_AUTO,
    BASE_OCT,
    BASE_DEC,
    BASE_HEX
  } base_t;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // acc holds the magnitude, nacc always holds its two's complement negation
  typedef struct packed {
    phase_t      phase;
    logic [63:0] acc;
    logic [63:0] nacc;
    logic        minus;
    base_t       base;
    logic        nonnul;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:  PH_SPACE,
    acc:    64'd0,
    nacc:   64'd0,
    minus:  1'b0,
    base:   BASE_DEC,
    nonnul: 1'b0
  };

  // one result transaction
  typedef struct packed {
    logic [63:0] value;
    logic        status;
  } parse_result_t;

endpackage : stp_pkg
`default_nettype wire

[rtl/stp_digit_acc.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stp_digit_acc
// digit decode and accumulate step: acc*radix + digit with wrap detect,
// plus the same step on the negated accumulator
// ----------------------------------------------------------------------------
module stp_digit_acc
  import stp_pkg::*;
(
  input  wire logic [7:0]  char_byte,
  input  wire base_t       base,
  input  wire logic [63:0] acc,
  input  wire logic [63:0] nacc,
  output logic             is_digit,
  output logic             ovf,
  output logic [63:0]      acc_nxt,
  output logic [63:0]      nacc_nxt
);

  logic [7:0]  off_num;
  logic [7:0]  off_lo;
  logic [7:0]  off_up;
  logic [3:0]  dval;
  logic        is_char;
  logic [67:0] dec_sum;
  logic [63:0] nacc_dec;

  assign off_num = char_byte - CH_ZERO;
  assign off_lo  = char_byte - CH_LOWER_A;
  assign off_up  = char_byte - CH_UPPER_A;

  always_comb begin
    is_char = 1'b1;
    dval    = 4'd0;
    if (char_byte >= CH_ZERO && char_byte <= CH_NINE) begin
      dval = off_num[3:0];
    end else if (char_byte >= CH_LOWER_A && char_byte <= CH_LOWER_F) begin
      dval = off_lo[3:0] + 4'd10;
    end else if (char_byte >= CH_UPPER_A && char_byte <= CH_UPPER_F) begin
      dval = off_up[3:0] + 4'd10;
    end else begin
      is_char = 1'b0;
    end
  end

  // acc*10 + d in 68 bits, wrap when anything lands above bit 63
  assign dec_sum  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {64'd0, dval};
  assign nacc_dec = {nacc[60:0], 3'b000} + {nacc[62:0], 1'b0} - {60'd0, dval};

  always_comb begin
    case (base)
      BASE_OCT: begin
        is_digit = is_char && !dval[3];
        ovf      = |acc[63:61];
        acc_nxt  = {acc[60:0], dval[2:0]};
        nacc_nxt = {nacc[60:0], 3'b000} - {60'd0, dval};
      end
      BASE_HEX: begin
        is_digit = is_char;
        ovf      = |acc[63:60];
        acc_nxt  = {acc[59:0], dval};
        nacc_nxt = {nacc[59:0], 4'b0000} - {60'd0, dval};
      end
      default: begin
        is_digit = is_char && (dval <= 4'd9);
        ovf      = |dec_sum[67:64];
        acc_nxt  = dec_sum[63:0];
        nacc_nxt = nacc_dec;
      end
    endcase
  end

endmodule : stp_digit_acc
`default_nettype wire

[rtl/stp_parse_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stp_parse_step
// next-state logic for one character: whitespace, sign, prefix and digit
// phases, and the result of a window on its final byte
// ----------------------------------------------------------------------------
module stp_parse_step
  import stp_pkg::*;
(
  input  wire parse_state_t  st,
  input  wire logic [7:0]    char_byte,
  input  wire base_t         number_base,
  output parse_state_t       st_nxt,
  output parse_result_t      res
);

  parse_state_t pre;
  logic         used;
  logic         go_digits;
  logic         stop_now;
  logic         is_digit;
  logic         ovf;
  logic [63:0]  acc_step;
  logic [63:0]  nacc_step;

  // prefix phases; several can pass in one character
  always_comb begin
    pre  = st;
    used = 1'b0;
    if (pre.phase == PH_SPACE) begin
      if (char_byte == CH_SPACE || (char_byte >= CH_TAB && char_byte <= CH_CR)) begin
        used = 1'b1;
      end else begin
        pre.phase = PH_SIGN;
      end
    end
    if (!used && pre.phase == PH_SIGN) begin
      if (char_byte == CH_MINUS) begin
        pre.minus = 1'b1;
        used      = 1'b1;
      end else if (char_byte == CH_PLUS) begin
        used = 1'b1;
      end
      if (number_base == BASE_AUTO) begin
        pre.base  = BASE_DEC;
        pre.phase = PH_ZERO;
      end else begin
        pre.base  = number_base;
        pre.phase = PH_DIGITS;
      end
    end
    if (!used && pre.phase == PH_ZERO) begin
      if (char_byte == CH_ZERO) begin
        pre.base  = BASE_OCT;
        pre.phase = PH_X;
        used      = 1'b1;
      end else begin
        pre.phase = PH_DIGITS;
      end
    end
    if (!used && pre.phase == PH_X) begin
      pre.phase = PH_DIGITS;
      if (char_byte == CH_LOWER_X || char_byte == CH_UPPER_X) begin
        pre.base = BASE_HEX;
        used     = 1'b1;
      end
    end
    go_digits = !used && pre.phase == PH_DIGITS;
  end

  stp_digit_acc u_digit (
    .char_byte (char_byte),
    .base      (pre.base),
    .acc       (pre.acc),
    .nacc      (pre.nacc),
    .is_digit  (is_digit),
    .ovf       (ovf),
    .acc_nxt   (acc_step),
    .nacc_nxt  (nacc_step)
  );

  always_comb begin
    st_nxt   = pre;
    stop_now = 1'b0;
    if (go_digits) begin
      if (!is_digit) begin
        st_nxt.phase  = PH_DONE;
        st_nxt.nonnul = (char_byte != CH_NUL);
        stop_now      = 1'b1;
      end else if (ovf) begin
        st_nxt.acc    = ALL_ONES;
        st_nxt.nacc   = 64'd1;
        st_nxt.phase  = PH_DONE;
        st_nxt.nonnul = 1'b1;
        stop_now      = 1'b1;
      end else begin
        st_nxt.acc  = acc_step;
        st_nxt.nacc = nacc_step;
      end
    end
    res.value  = st_nxt.minus ? st_nxt.nacc : st_nxt.acc;
    res.status = (st_nxt.phase == PH_DONE) && !stop_now && st_nxt.nonnul;
  end

endmodule : stp_parse_step
`default_nettype wire

[rtl/string_to_integer_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// string_to_integer_parser
// streams a character window one byte per transaction and returns the
// parsed 64-bit integer and a status when the window's last byte arrives
// ----------------------------------------------------------------------------
// usage
//   in_*  : one character per transaction, in_tlast marks the window's last byte
//   out_* : one transaction per window, value in out_tdata, status in out_tuser
//   cfg_* : number base, written while the block is idle; it is sampled when
//           the sign position of a window is passed, so it applies per window
// timing
//   a byte is held in the input register, then the parse step updates the
//   state and, on the last byte, loads the result register, whose valid flag
//   drives out_tvalid; a held result can stall the last byte in between
//   one byte per cycle while no last byte waits behind an untaken result; the
//   parse step turns over with each byte, the limit being the 64-bit
//   multiply-add by the radix
// reset
//   rst_n low clears the window state, the input and result valid flags and
//   sets the number base to auto-detect
// stall
//   a held result blocks only a last byte; other bytes keep flowing, and
//   in_tready drops once a last byte waits behind an untaken result
// ----------------------------------------------------------------------------
module string_to_integer_parser
  import stp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,   // number_base
  // character stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [7:0] char_byte
  input  wire logic        in_tlast,      // window_end
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,     // [63:0] parsed_value
  output logic             out_tuser      // [0] parse_status
);

  base_t         number_base_r;
  parse_state_t  state_r;
  parse_state_t  step_state;
  parse_result_t step_res;

  logic          in_valid_r;
  logic [7:0]    in_char_r;
  logic          in_last_r;

  logic          out_valid_r;
  parse_result_t out_res_r;

  logic          out_free;
  logic          step_fire;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= BASE_AUTO;
    end else if (cfg_wr_en) begin
      number_base_r <= base_t'(cfg_wr_data);
    end
  end

  // result register frees when empty or being taken this cycle
  assign out_free  = !out_valid_r || out_tready;
  // a non-last byte never produces a result and always proceeds
  assign step_fire = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || step_fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  stp_parse_step u_step (
    .st          (state_r),
    .char_byte   (in_char_r),
    .number_base (number_base_r),
    .st_nxt      (step_state),
    .res         (step_res)
  );

  // window state, back to reset after each last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (step_fire) begin
      state_r <= in_last_r ? STATE_RESET : step_state;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && in_last_r) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.value;
  assign out_tuser  = out_res_r.status;

  // a result appears only from a last byte passing the parse step
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step_fire && in_last_r))
    else $error("result without a last byte");

  // the negated accumulator tracks the accumulator at all times
  a_nacc_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.nacc == (64'd0 - state_r.acc))
    else $error("negated accumulator out of step");

  // a window's last byte restarts the state
  a_window_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire && in_last_r |=> state_r.phase == PH_SPACE && !state_r.minus
      && state_r.acc == 64'd0)
    else $error("state not restarted after window");

  // a stalled last byte stays in the input register
  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && in_last_r && !step_fire |=> in_valid_r && in_last_r)
    else $error("stalled last byte lost");

endmodule : string_to_integer_parser
`default_nettype wire
